@@ hw/rtl/xcpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xcpc_pkg
// Shared types and constants for the chained XOR packet cipher.
// ----------------------------------------------------------------------------
package xcpc_pkg;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = JOB_PTR_W + 1;

    localparam logic [7:0] HDR_EXT_BYTE = 8'h00;

    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  last_idx;
        logic        fin;
    } job_t;

endpackage
`default_nettype wire

@@ hw/rtl/xcpc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xcpc_front
// Accepts packet bytes, tracks header, chain and held bytes, and turns each
// transaction into a job of one to four result bytes, or holds its byte.
// ----------------------------------------------------------------------------
module xcpc_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         in_byte,
    input  wire logic               first_byte,
    input  wire logic               final_byte,
    input  wire logic [31:0]        packet_seed,
    output xcpc_pkg::job_t          job,
    output logic                    job_valid
);

    logic [31:0] chain_reg, chain_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [1:0]  header_left_reg, header_left_next;
    logic [7:0]  held_reg [3];
    logic        hold_wr;
    logic [7:0]  key;
    logic [31:0] cipher_word;

    assign key         = chain_reg[7:0];
    assign cipher_word = {in_byte, held_reg[2], held_reg[1], held_reg[0]} ^ chain_reg;

    always_comb
    begin
        chain_next       = chain_reg;
        held_count_next  = held_count_reg;
        header_left_next = header_left_reg;
        hold_wr          = 1'b0;
        job_valid        = 1'b0;
        job.data         = {24'd0, in_byte};
        job.last_idx     = 2'd0;
        job.fin          = final_byte;
        if (first_byte)
        begin
            chain_next       = packet_seed;
            held_count_next  = 2'd0;
            header_left_next = (in_byte == xcpc_pkg::HDR_EXT_BYTE && !final_byte) ? 2'd1 : 2'd0;
            job_valid        = 1'b1;
        end
        else if (header_left_reg != 2'd0)
        begin
            header_left_next = final_byte ? 2'd0 : header_left_reg - 2'd1;
            job_valid        = 1'b1;
        end
        else if (held_count_reg == 2'd3)
        begin
            chain_next      = cipher_word;
            held_count_next = 2'd0;
            job.data        = cipher_word;
            job.last_idx    = 2'd3;
            job_valid       = 1'b1;
        end
        else if (final_byte)
        begin
            for (int i = 0; i < 3; i++)
            begin
                job.data[i*8 +: 8] = (2'(i) < held_count_reg) ? (held_reg[i] ^ key)
                                                              : (in_byte ^ key);
            end
            job.data[31:24]  = in_byte ^ key;
            job.last_idx     = held_count_reg;
            held_count_next  = 2'd0;
            header_left_next = 2'd0;
            job_valid        = 1'b1;
        end
        else
        begin
            hold_wr         = 1'b1;
            held_count_next = held_count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg       <= '0;
            held_count_reg  <= '0;
            header_left_reg <= '0;
        end
        else if (accept)
        begin
            chain_reg       <= chain_next;
            held_count_reg  <= held_count_next;
            header_left_reg <= header_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_wr)
        begin
            held_reg[held_count_reg] <= in_byte;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/xcpc_job_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xcpc_job_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module xcpc_job_fifo
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire xcpc_pkg::job_t     wr_job,
    input  wire logic               rd_en,
    output xcpc_pkg::job_t          rd_job,
    output logic                    fifo_full,
    output logic                    fifo_empty
);

    xcpc_pkg::job_t                   mem_reg [xcpc_pkg::JOB_DEPTH];
    logic [xcpc_pkg::JOB_PTR_W-1:0]   wr_ptr_reg;
    logic [xcpc_pkg::JOB_PTR_W-1:0]   rd_ptr_reg;
    logic [xcpc_pkg::JOB_CNT_W-1:0]   count_reg;

    assign fifo_full  = (count_reg == xcpc_pkg::JOB_CNT_W'(xcpc_pkg::JOB_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_job     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/xcpc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xcpc_back
// Takes jobs from the queue and emits their bytes one per cycle through an
// output register, holding while a pending output byte is not popped.
// ----------------------------------------------------------------------------
module xcpc_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire xcpc_pkg::job_t     head_job,
    input  wire logic               head_empty,
    output logic                    head_take,
    input  wire logic               pop,
    output logic                    empty,
    output logic [7:0]              out_byte,
    output logic                    packet_end,
    output logic                    run_end
);

    xcpc_pkg::job_t job_reg;
    logic           job_valid_reg;
    logic [1:0]     idx_reg;
    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic           packet_end_reg;
    logic           run_end_reg;
    logic           adv;
    logic           job_last;

    assign adv       = job_valid_reg && (!out_valid_reg || pop);
    assign job_last  = (idx_reg == job_reg.last_idx);
    assign head_take = !head_empty && (!job_valid_reg || (adv && job_last));

    assign empty      = !out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign packet_end = packet_end_reg;
    assign run_end    = run_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (head_take)
            begin
                job_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (adv)
            begin
                job_valid_reg <= !job_last;
                idx_reg       <= idx_reg + 2'd1;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_take)
        begin
            job_reg <= head_job;
        end
        if (adv)
        begin
            out_byte_reg   <= job_reg.data[idx_reg*8 +: 8];
            run_end_reg    <= job_last;
            packet_end_reg <= job_last && job_reg.fin;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/xor_chained_packet_cipher.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xor_chained_packet_cipher
// Path: the first result byte of a transaction reaches the outputs through
// the queue write, the job load and the output register.
// Throughput: one input byte per cycle while not full; one result byte per cycle
// while pop is held, so a completed word yields four bytes; a 4-job queue buffers.
// Reset: asynchronous, clears chain, header and held counts and the job queue.
// ----------------------------------------------------------------------------
module xor_chained_packet_cipher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        first_byte,
    input  wire logic        final_byte,
    input  wire logic [31:0] packet_seed,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             packet_end,
    output logic             run_end
);

    logic           accept;
    xcpc_pkg::job_t new_job;
    logic           new_job_valid;
    xcpc_pkg::job_t head_job;
    logic           head_empty;
    logic           head_take;
    logic           fifo_full;

    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    xcpc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .first_byte  (first_byte),
        .final_byte  (final_byte),
        .packet_seed (packet_seed),
        .job         (new_job),
        .job_valid   (new_job_valid)
    );

    xcpc_job_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept && new_job_valid),
        .wr_job     (new_job),
        .rd_en      (head_take),
        .rd_job     (head_job),
        .fifo_full  (fifo_full),
        .fifo_empty (head_empty)
    );

    xcpc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_empty (head_empty),
        .head_take  (head_take),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .run_end    (run_end)
    );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chained XOR packet cipher. It starts with a
// directed table (pass-through headers, short packets, full and partial words,
// restarts while bytes are held, stray bytes), then runs random packets. Both
// sides idle in random bursts, and the output side stalls once for a long
// stretch so that the input side sees full. Each result byte is checked
// against the behavioral cipher model or, for rows marked fixed, the table's result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  DIRECTED_ROWS = 25;
    localparam int  TOTAL_BYTES   = 480;
    localparam int  CALM_AFTER    = 420;
    localparam int  HOLD_AT       = 150;
    localparam int  HOLD_CYCLES   = 80;
    localparam int  DRAIN_CYCLES  = 20;
    localparam int  CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       pend;
        logic       rend;
    } cipher_out_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        fin;
        logic [31:0] seed;
        logic        fixed;
        cipher_out_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        first_byte;
    logic        final_byte;
    logic [31:0] packet_seed;
    logic        pop;
    logic        empty;
    logic [7:0]  out_byte;
    logic        packet_end;
    logic        run_end;

    // cipher model state
    logic [31:0] chain_key;
    logic [7:0]  held_q [3];
    int          held_n;
    int          hdr_left;
    cipher_out_t step_res [4];

    cipher_out_t expected_bytes [$];

    int  bytes_taken;
    int  packets_started;
    int  results_checked;
    int  words_done;
    int  mismatches;
    int  cycle_count;
    bit  calm;
    bit  long_hold_done;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'h5A, 1'b0, 1'b1, 32'h0000_0000, 1'b1, '{8'h5A, 1'b1, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        '{8'h00, 1'b1, 1'b1, 32'hA5A5_A5A5, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{8'h00, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b1, '{8'hFF, 1'b0, 1'b1}},
        '{8'h00, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, 32'h0000_0000, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, 32'h0000_0000, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{8'h80, 1'b0, 1'b1, 32'h0000_0000, 1'b1, '{8'h80, 1'b1, 1'b1}},
        '{8'h7E, 1'b1, 1'b0, 32'h1234_5678, 1'b1, '{8'h7E, 1'b0, 1'b1}},
        '{8'h01, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{8'h03, 1'b0, 1'b1, 32'h0000_0000, 1'b0, '0},
        '{8'h01, 1'b1, 1'b0, 32'hDEAD_BEEF, 1'b1, '{8'h01, 1'b0, 1'b1}},
        '{8'hAA, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{8'hBB, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{8'h42, 1'b1, 1'b0, 32'h0000_0000, 1'b1, '{8'h42, 1'b0, 1'b1}},
        '{8'h55, 1'b0, 1'b1, 32'h0000_0000, 1'b0, '0},
        '{8'h10, 1'b0, 1'b1, 32'h0000_0000, 1'b0, '0}
    };

    xor_chained_packet_cipher u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .first_byte  (first_byte),
        .final_byte  (final_byte),
        .packet_seed (packet_seed),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .packet_end  (packet_end),
        .run_end     (run_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int cipher_predict(input logic [7:0] b, input logic f,
                                          input logic l, input logic [31:0] s);
        logic [31:0] word;
        logic [7:0]  key;
        int          n;
        int          i;
        if (f)
        begin
            chain_key   = s;
            held_n      = 0;
            hdr_left    = (b == xcpc_pkg::HDR_EXT_BYTE && !l) ? 1 : 0;
            step_res[0] = '{b, l, 1'b1};
            return 1;
        end
        if (hdr_left != 0)
        begin
            hdr_left    = l ? 0 : hdr_left - 1;
            step_res[0] = '{b, l, 1'b1};
            return 1;
        end
        if (held_n == 3)
        begin
            word      = {b, held_q[2], held_q[1], held_q[0]} ^ chain_key;
            chain_key = word;
            held_n    = 0;
            words_done++;
            for (i = 0; i < 4; i++)
                step_res[i] = '{word[8*i +: 8], l && (i == 3), i == 3};
            return 4;
        end
        if (l)
        begin
            key = chain_key[7:0];
            for (i = 0; i < held_n; i++)
                step_res[i] = '{held_q[i] ^ key, 1'b0, 1'b0};
            step_res[held_n] = '{b ^ key, 1'b1, 1'b1};
            n      = held_n + 1;
            held_n = 0;
            return n;
        end
        held_q[held_n] = b;
        held_n++;
        return 0;
    endfunction

    task automatic drive_byte(input logic [7:0] b, input logic f, input logic l,
                              input logic [31:0] s, input logic fixed,
                              input cipher_out_t fixed_res);
        int gap;
        int n;
        int i;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap  = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push        <= 1'b1;
        in_byte     <= b;
        first_byte  <= f;
        final_byte  <= l;
        packet_seed <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        n = cipher_predict(b, f, l, s);
        if (fixed)
            expected_bytes.push_back(fixed_res);
        else
            for (i = 0; i < n; i++)
                expected_bytes.push_back(step_res[i]);
        bytes_taken++;
        if (f)
            packets_started++;
        if (bytes_taken >= CALM_AFTER)
            calm = 1'b1;
        @(negedge clk);
    endtask

    task automatic send_packet(input int len, input bit ended);
        logic [31:0] seed;
        logic [7:0]  b;
        int          k;
        seed = $urandom;
        b    = ($urandom_range(0, 2) == 0) ? xcpc_pkg::HDR_EXT_BYTE
                                           : 8'($urandom_range(0, 255));
        drive_byte(b, 1'b1, ended && len == 1, seed, 1'b0, '0);
        for (k = 1; k < len; k++)
        begin
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            drive_byte(b, 1'b0, ended && k == len - 1, $urandom, 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        cipher_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected result: out_byte %02h packet_end %0b run_end %0b",
                         $time, out_byte, packet_end, run_end);
                mismatches++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                results_checked++;
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, out_byte);
                    mismatches++;
                end
                if (packet_end !== want.pend)
                begin
                    $display("%0t: packet_end expected %0b actual %0b",
                             $time, want.pend, packet_end);
                    mismatches++;
                end
                if (run_end !== want.rend)
                begin
                    $display("%0t: run_end expected %0b actual %0b",
                             $time, want.rend, run_end);
                    mismatches++;
                end
            end
        end
    end

    // output side: random stalls, one long hold-off
    initial
    begin : drain_side
        int stall_left;
        stall_left = 0;
        pop        = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && bytes_taken >= HOLD_AT)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold_done = 1'b1;
            end
            if (!calm && stall_left == 0 && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0 && !calm)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                stall_left = 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_bytes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : feed_side
        int r;
        int len;
        chain_key       = '0;
        held_n          = 0;
        hdr_left        = 0;
        bytes_taken     = 0;
        packets_started = 0;
        results_checked = 0;
        words_done      = 0;
        mismatches      = 0;
        cycle_count     = 0;
        calm            = 1'b0;
        long_hold_done  = 1'b0;
        rst_n           = 1'b0;
        push            = 1'b0;
        in_byte         = '0;
        first_byte      = 1'b0;
        final_byte      = 1'b0;
        packet_seed     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < DIRECTED_ROWS; k++)
            drive_byte(directed_rows[k].data, directed_rows[k].first,
                       directed_rows[k].fin, directed_rows[k].seed,
                       directed_rows[k].fixed, directed_rows[k].res);

        while (bytes_taken < TOTAL_BYTES)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                drive_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                           $urandom, 1'b0, '0);
            else
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24)
                                                  : $urandom_range(1, 12);
                send_packet(len, r != 1);
            end
        end
        push <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input bytes in %0d packet starts with one long output stall.",
                 bytes_taken, packets_started);
        $display("Checked %0d result bytes, %0d full words encrypted, %0d mismatches.",
                 results_checked, words_done, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
